// ===== rtl/core/lfsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfsp_pkg;

  // parse phase codes
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_D       = 3'd1;
  localparam logic [2:0] PH_A       = 3'd2;
  localparam logic [2:0] PH_HI      = 3'd3;
  localparam logic [2:0] PH_LO      = 3'd4;
  localparam logic [2:0] PH_CHK     = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;

  // input item kinds
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // result item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ABORT = 1'b1;

  // header bytes
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_LOWER_D = 8'h64;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHK_SALT    = 8'h55;

  // register indexes
  localparam logic REG_LED_COUNT = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  localparam logic [10:0] LED_COUNT_RST = 11'd75;
  localparam logic [15:0] TIMEOUT_RST   = 16'd10;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

endpackage

`default_nettype wire

// ===== rtl/core/led_frame_stream_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// LED frame stream parser
// Slave stream: one item per received serial byte (tuser = 0, tdata = byte)
// or per time tick (tuser = 1). The parser hunts for the 'A' header byte,
// checks the five header bytes that follow and then takes led_count * 3
// payload bytes as R, G, B per LED.
// Master stream: one pixel item per completed triple (tuser = 0), tlast on the
// final pixel of the frame; an abort item (tuser = 1) when payload ticks
// reach timeout_ticks without a byte.
// Every item is handled by the state update and lands in the result register:
// a result is visible in the cycle after its input item is accepted, and one
// item can be accepted each cycle unless a stalled receiver holds the input.
// The single result register sets the rate: s_tready is low only while a
// result is held and m_tready is low, so a stalled receiver stalls the input.
// Reset (rst, synchronous) returns to hunting, clears the output valid and
// loads led_count = 75 and timeout_ticks = 10.
// Registers over APB: led_count at 0x0, timeout_ticks at 0x4.

module led_frame_stream_parser_unit #(
  parameter int MAX_LEDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] action
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [9:0] led_index, [17:10] red,
                                      // [25:18] green, [33:26] blue, zero pad
  output logic             m_tuser,   // [0] kind
  output logic             m_tlast,   // last
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PIX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CMP_W = (PIX_W + 1 > 11) ? PIX_W + 1 : 11;
  localparam int IDX_W = (PIX_W > 10) ? PIX_W : 10;

  // configuration registers
  logic [10:0] led_count;
  logic [15:0] timeout_ticks;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count     <= lfsp_pkg::LED_COUNT_RST;
      timeout_ticks <= lfsp_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == lfsp_pkg::REG_LED_COUNT) begin
        led_count <= pwdata[10:0];
      end else begin
        timeout_ticks <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == lfsp_pkg::REG_LED_COUNT) begin
      prdata = {21'd0, led_count};
    end else begin
      prdata = {16'd0, timeout_ticks};
    end
  end

  // parser state
  logic [2:0]       parse_phase, parse_phase_next;
  logic [7:0]       header_d, header_a, count_high, count_low;
  logic [1:0]       byte_in_pixel, byte_in_pixel_next;
  logic [PIX_W-1:0] pixel_number, pixel_number_next;
  logic [7:0]       red_hold, green_hold;
  logic [15:0]      idle_count, idle_count_next;

  // result register
  logic             out_kind, out_last;
  logic [9:0]       out_idx;
  logic [7:0]       out_red, out_green, out_blue;

  logic             res_valid, res_kind, res_last;
  logic             in_acc;
  logic [CMP_W-1:0] frame_leds, pix_plus;
  logic [15:0]      idle_inc;
  logic [IDX_W-1:0] pix_wide;

  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;

  // effective frame length: zero acts as one, clamp to MAX_LEDS
  always_comb begin
    frame_leds = CMP_W'(led_count);
    if (led_count == 11'd0) begin
      frame_leds = CMP_W'(1);
    end else if (CMP_W'(led_count) > CMP_W'(MAX_LEDS)) begin
      frame_leds = CMP_W'(MAX_LEDS);
    end
  end

  assign pix_plus = CMP_W'(pixel_number) + CMP_W'(1);
  assign idle_inc = (idle_count == lfsp_pkg::IDLE_MAX) ? idle_count
                                                       : idle_count + 16'd1;
  assign pix_wide = IDX_W'(pixel_number);

  // next state and result for the item at the input
  always_comb begin
    parse_phase_next   = parse_phase;
    byte_in_pixel_next = byte_in_pixel;
    pixel_number_next  = pixel_number;
    idle_count_next    = idle_count;
    res_valid          = 1'b0;
    res_kind           = lfsp_pkg::KIND_PIXEL;
    res_last           = 1'b0;
    if (s_tuser == lfsp_pkg::ACT_TICK) begin
      if (parse_phase == lfsp_pkg::PH_PAYLOAD) begin
        if (idle_inc >= timeout_ticks) begin
          res_valid          = 1'b1;
          res_kind           = lfsp_pkg::KIND_ABORT;
          parse_phase_next   = lfsp_pkg::PH_HUNT;
          byte_in_pixel_next = 2'd0;
          pixel_number_next  = '0;
          idle_count_next    = 16'd0;
        end else begin
          idle_count_next = idle_inc;
        end
      end
    end else begin
      unique case (parse_phase)
        lfsp_pkg::PH_HUNT: begin
          if (s_tdata == lfsp_pkg::CHR_UPPER_A) parse_phase_next = lfsp_pkg::PH_D;
        end
        lfsp_pkg::PH_D:  parse_phase_next = lfsp_pkg::PH_A;
        lfsp_pkg::PH_A:  parse_phase_next = lfsp_pkg::PH_HI;
        lfsp_pkg::PH_HI: parse_phase_next = lfsp_pkg::PH_LO;
        lfsp_pkg::PH_LO: parse_phase_next = lfsp_pkg::PH_CHK;
        lfsp_pkg::PH_CHK: begin
          if (header_d == lfsp_pkg::CHR_LOWER_D && header_a == lfsp_pkg::CHR_LOWER_A &&
              s_tdata == (count_high ^ count_low ^ lfsp_pkg::CHK_SALT)) begin
            parse_phase_next   = lfsp_pkg::PH_PAYLOAD;
            byte_in_pixel_next = 2'd0;
            pixel_number_next  = '0;
            idle_count_next    = 16'd0;
          end else begin
            parse_phase_next = lfsp_pkg::PH_HUNT;
          end
        end
        lfsp_pkg::PH_PAYLOAD: begin
          idle_count_next = 16'd0;
          if (byte_in_pixel == 2'd0) begin
            byte_in_pixel_next = 2'd1;
          end else if (byte_in_pixel == 2'd1) begin
            byte_in_pixel_next = 2'd2;
          end else begin
            res_valid          = 1'b1;
            res_last           = (pix_plus >= frame_leds);
            byte_in_pixel_next = 2'd0;
            if (res_last) begin
              parse_phase_next  = lfsp_pkg::PH_HUNT;
              pixel_number_next = '0;
            end else begin
              pixel_number_next = pix_plus[PIX_W-1:0];
            end
          end
        end
        default: parse_phase_next = lfsp_pkg::PH_HUNT;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= lfsp_pkg::PH_HUNT;
      byte_in_pixel <= 2'd0;
      pixel_number  <= '0;
      idle_count    <= 16'd0;
      header_d      <= 8'd0;
      header_a      <= 8'd0;
      count_high    <= 8'd0;
      count_low     <= 8'd0;
      red_hold      <= 8'd0;
      green_hold    <= 8'd0;
    end else if (in_acc) begin
      parse_phase   <= parse_phase_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixel_number  <= pixel_number_next;
      idle_count    <= idle_count_next;
      if (s_tuser == lfsp_pkg::ACT_BYTE) begin
        if (parse_phase == lfsp_pkg::PH_D)  header_d   <= s_tdata;
        if (parse_phase == lfsp_pkg::PH_A)  header_a   <= s_tdata;
        if (parse_phase == lfsp_pkg::PH_HI) count_high <= s_tdata;
        if (parse_phase == lfsp_pkg::PH_LO) count_low  <= s_tdata;
        if (parse_phase == lfsp_pkg::PH_PAYLOAD && byte_in_pixel == 2'd0) begin
          red_hold <= s_tdata;
        end
        if (parse_phase == lfsp_pkg::PH_PAYLOAD && byte_in_pixel == 2'd1) begin
          green_hold <= s_tdata;
        end
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= in_acc && res_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_kind <= res_kind;
      out_last <= res_last;
      out_idx  <= pix_wide[9:0];
      if (res_kind == lfsp_pkg::KIND_ABORT) begin
        out_red   <= 8'd0;
        out_green <= 8'd0;
        out_blue  <= 8'd0;
      end else begin
        out_red   <= red_hold;
        out_green <= green_hold;
        out_blue  <= s_tdata;
      end
    end
  end

  assign m_tdata = {6'd0, out_blue, out_green, out_red, out_idx};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

`default_nettype wire

// ===== tb/tb_led_frame_stream_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_led_frame_stream_parser_unit;

  localparam int LED_CAP = 1024;
  localparam int LIMIT_CYCLES = 400000;

  // one result item as seen on the master stream
  typedef struct packed {
    logic       kind;
    logic [9:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } led_item_t;

  // directed row: input item plus an optional typed-in result
  typedef struct packed {
    logic       act;
    logic [7:0] dat;
    logic       pinned;
    led_item_t  res;
  } stim_row_t;

  localparam led_item_t NO_RES = '0;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic        s_tuser;   // [0] action
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [9:0] led_index, [17:10] red, [25:18] green, [33:26] blue
  logic        m_tuser;   // [0] kind
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  led_frame_stream_parser_unit #(
    .MAX_LEDS(LED_CAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // parser model state and configuration
  logic [2:0]  m_phase;
  logic [7:0]  m_hd;
  logic [7:0]  m_ha;
  logic [7:0]  m_hi;
  logic [7:0]  m_lo;
  logic [1:0]  m_bip;
  logic [10:0] m_pix;
  logic [7:0]  m_red;
  logic [7:0]  m_green;
  logic [15:0] m_idle;
  logic [10:0] m_leds;
  logic [15:0] m_tmo;

  led_item_t   due_results[$];
  logic        pin_on;
  led_item_t   pin_res;
  int          errors;
  int          n_results;
  int          n_items;
  int          cycles;
  logic        calm;

  stim_row_t   plan [28];

  always #5 clk = ~clk;

  // parse one input item, returns 1 when it yields a result
  function automatic logic parse_item(input logic act, input logic [7:0] dat,
                                      output led_item_t res);
    logic [10:0] n_leds;
    logic        fin;
    res = NO_RES;
    parse_item = 1'b0;
    if (act == lfsp_pkg::ACT_TICK) begin
      if (m_phase == lfsp_pkg::PH_PAYLOAD) begin
        if (m_idle != lfsp_pkg::IDLE_MAX) m_idle = m_idle + 16'd1;
        if (m_idle >= m_tmo) begin
          res.kind = lfsp_pkg::KIND_ABORT;
          res.idx = m_pix[9:0];
          m_phase = lfsp_pkg::PH_HUNT;
          m_bip = 2'd0;
          m_pix = 11'd0;
          m_idle = 16'd0;
          parse_item = 1'b1;
        end
      end
    end else begin
      case (m_phase)
        lfsp_pkg::PH_HUNT: begin
          if (dat == lfsp_pkg::CHR_UPPER_A) m_phase = lfsp_pkg::PH_D;
        end
        lfsp_pkg::PH_D: begin
          m_hd = dat;
          m_phase = lfsp_pkg::PH_A;
        end
        lfsp_pkg::PH_A: begin
          m_ha = dat;
          m_phase = lfsp_pkg::PH_HI;
        end
        lfsp_pkg::PH_HI: begin
          m_hi = dat;
          m_phase = lfsp_pkg::PH_LO;
        end
        lfsp_pkg::PH_LO: begin
          m_lo = dat;
          m_phase = lfsp_pkg::PH_CHK;
        end
        lfsp_pkg::PH_CHK: begin
          if (m_hd == lfsp_pkg::CHR_LOWER_D && m_ha == lfsp_pkg::CHR_LOWER_A &&
              dat == (m_hi ^ m_lo ^ lfsp_pkg::CHK_SALT)) begin
            m_phase = lfsp_pkg::PH_PAYLOAD;
            m_bip = 2'd0;
            m_pix = 11'd0;
            m_idle = 16'd0;
          end else begin
            m_phase = lfsp_pkg::PH_HUNT;
          end
        end
        lfsp_pkg::PH_PAYLOAD: begin
          m_idle = 16'd0;
          if (m_bip == 2'd0) begin
            m_red = dat;
            m_bip = 2'd1;
          end else if (m_bip == 2'd1) begin
            m_green = dat;
            m_bip = 2'd2;
          end else begin
            // zero leds counts as one, large counts clamp
            n_leds = (m_leds == 11'd0) ? 11'd1 :
                     (m_leds > 11'(LED_CAP)) ? 11'(LED_CAP) : m_leds;
            fin = (m_pix + 11'd1 >= n_leds);
            res = {lfsp_pkg::KIND_PIXEL, m_pix[9:0], m_red, m_green, dat, fin};
            m_bip = 2'd0;
            if (fin) begin
              m_phase = lfsp_pkg::PH_HUNT;
              m_pix = 11'd0;
            end else begin
              m_pix = m_pix + 11'd1;
            end
            parse_item = 1'b1;
          end
        end
        default: begin
          m_phase = lfsp_pkg::PH_HUNT;
        end
      endcase
    end
  endfunction

  task automatic report(input string field, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
             n_results, field, got, want);
    errors++;
  endtask

  // drive one item and hold it until accepted
  task automatic send_item(input logic act, input logic [7:0] dat,
                           input logic pinned, input led_item_t res);
    while (!calm && $urandom_range(0, 99) < 37) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= dat;
    pin_on <= pinned;
    pin_res <= res;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    n_items++;
    calm = (n_items >= 600 && n_items < 1000);
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    s_tvalid <= 1'b0;
    pin_on <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // random frames under one register setting
  task automatic run_phase(input logic [10:0] leds, input logic [15:0] tmo,
                           input int budget);
    int         done;
    int         eff;
    int         frame_px;
    int         corrupt;
    int         cut;
    int         gap_max;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] hd;
    logic [7:0] ha;
    logic [7:0] ck;
    logic [7:0] hdr [6];
    drain();
    write_reg(lfsp_pkg::REG_LED_COUNT, 32'(leds));
    write_reg(lfsp_pkg::REG_TIMEOUT, 32'(tmo));
    eff = (tmo == 16'd0) ? 1 : int'(tmo);
    frame_px = (leds == 11'd0) ? 1 : (leds > 11'(LED_CAP)) ? LED_CAP : int'(leds);
    gap_max = (eff - 1 > 5) ? 5 : eff - 1;
    done = 0;
    while (done < budget) begin
      // line noise between frames
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, NO_RES);
      end
      // header, sometimes broken
      corrupt = $urandom_range(0, 9);
      hi = 8'($urandom_range(0, 255));
      lo = 8'($urandom_range(0, 255));
      hd = lfsp_pkg::CHR_LOWER_D;
      ha = lfsp_pkg::CHR_LOWER_A;
      ck = hi ^ lo ^ lfsp_pkg::CHK_SALT;
      if (corrupt == 0) hd = hd ^ 8'($urandom_range(1, 255));
      if (corrupt == 1) ha = ha ^ 8'($urandom_range(1, 255));
      if (corrupt == 2) ck = ck ^ 8'($urandom_range(1, 255));
      hdr = '{lfsp_pkg::CHR_UPPER_A, hd, ha, hi, lo, ck};
      foreach (hdr[i]) begin
        if (i > 0 && $urandom_range(0, 9) == 0)
          send_item(lfsp_pkg::ACT_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_RES);
        send_item(lfsp_pkg::ACT_BYTE, hdr[i], 1'b0, NO_RES);
      end
      done += 6;
      // payload with short tick gaps, now and then cut by a timeout
      if (corrupt >= 3) begin
        cut = (eff <= 20 && $urandom_range(0, 4) == 0) ?
              int'($urandom_range(0, frame_px * 3 - 1)) : -1;
        for (int j = 0; j < frame_px * 3; j++) begin
          if (j == cut) begin
            repeat (eff)
              send_item(lfsp_pkg::ACT_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_RES);
            done += eff;
            break;
          end
          if (gap_max > 0 && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, gap_max))
              send_item(lfsp_pkg::ACT_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_RES);
          end
          send_item(lfsp_pkg::ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_RES);
          done++;
        end
      end
    end
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 37);
  end

  // result checking, prediction and register tracking
  always @(posedge clk) begin : scoreboard
    led_item_t got;
    led_item_t want;
    led_item_t pred;
    logic      hit;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[9:0], m_tdata[17:10], m_tdata[25:18], m_tdata[33:26],
               m_tlast};
        if (due_results.size() == 0) begin
          report("unexpected result", longint'(got), 64'd0);
        end else begin
          want = due_results.pop_front();
          if (got.kind != want.kind)
            report("kind", longint'(got.kind), longint'(want.kind));
          if (got.idx != want.idx)
            report("led_index", longint'(got.idx), longint'(want.idx));
          if (got.red != want.red)
            report("red", longint'(got.red), longint'(want.red));
          if (got.green != want.green)
            report("green", longint'(got.green), longint'(want.green));
          if (got.blue != want.blue)
            report("blue", longint'(got.blue), longint'(want.blue));
          if (got.last != want.last)
            report("last", longint'(got.last), longint'(want.last));
        end
        n_results++;
      end
      if (s_tvalid && s_tready) begin
        hit = parse_item(s_tuser, s_tdata, pred);
        if (pin_on) due_results.push_back(pin_res);
        else if (hit) due_results.push_back(pred);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {lfsp_pkg::REG_LED_COUNT, 2'b00}) m_leds = pwdata[10:0];
        if (paddr == {lfsp_pkg::REG_TIMEOUT, 2'b00}) m_tmo = pwdata[15:0];
      end
    end
  end

  // stimulus
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = lfsp_pkg::ACT_BYTE;
    s_tdata = 8'h00;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    pin_on = 1'b0;
    pin_res = NO_RES;
    errors = 0;
    n_results = 0;
    n_items = 0;
    cycles = 0;
    calm = 1'b0;
    m_phase = lfsp_pkg::PH_HUNT;
    m_hd = 8'h00;
    m_ha = 8'h00;
    m_hi = 8'h00;
    m_lo = 8'h00;
    m_bip = 2'd0;
    m_pix = 11'd0;
    m_red = 8'h00;
    m_green = 8'h00;
    m_idle = 16'd0;
    m_leds = lfsp_pkg::LED_COUNT_RST;
    m_tmo = lfsp_pkg::TIMEOUT_RST;

    // two led frames, single tick timeout
    plan = '{
      // tick and stray byte while hunting
      {lfsp_pkg::ACT_TICK, 8'h00, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'hFF, 1'b0, NO_RES},
      // good header, checksum ff ^ 00 ^ 55
      {lfsp_pkg::ACT_BYTE, lfsp_pkg::CHR_UPPER_A, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, lfsp_pkg::CHR_LOWER_D, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, lfsp_pkg::CHR_LOWER_A, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'hFF, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'h00, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'hAA, 1'b0, NO_RES},
      // two pixels at full swing, last on the second
      {lfsp_pkg::ACT_BYTE, 8'hFF, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'h00, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'hFF, 1'b1,
       {lfsp_pkg::KIND_PIXEL, 10'd0, 8'hFF, 8'h00, 8'hFF, 1'b0}},
      {lfsp_pkg::ACT_BYTE, 8'h00, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'hFF, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'h00, 1'b1,
       {lfsp_pkg::KIND_PIXEL, 10'd1, 8'h00, 8'hFF, 8'h00, 1'b1}},
      // bad checksum goes back to hunting
      {lfsp_pkg::ACT_BYTE, lfsp_pkg::CHR_UPPER_A, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, lfsp_pkg::CHR_LOWER_D, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, lfsp_pkg::CHR_LOWER_A, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'h12, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'h34, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'h00, 1'b0, NO_RES},
      // good header, one payload byte, then a tick aborts
      {lfsp_pkg::ACT_BYTE, lfsp_pkg::CHR_UPPER_A, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, lfsp_pkg::CHR_LOWER_D, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, lfsp_pkg::CHR_LOWER_A, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'h00, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'h00, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, lfsp_pkg::CHK_SALT, 1'b0, NO_RES},
      {lfsp_pkg::ACT_BYTE, 8'h80, 1'b0, NO_RES},
      {lfsp_pkg::ACT_TICK, 8'hFF, 1'b1,
       {lfsp_pkg::KIND_ABORT, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0}}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_reg(lfsp_pkg::REG_LED_COUNT, 32'd2);
    write_reg(lfsp_pkg::REG_TIMEOUT, 32'd1);
    foreach (plan[i]) send_item(plan[i].act, plan[i].dat, plan[i].pinned, plan[i].res);

    run_phase(11'd1, 16'd0, 200);
    run_phase(11'd3, 16'd2, 250);
    run_phase(11'd40, 16'd65535, 200);
    run_phase(11'd0, 16'd5, 200);
    run_phase(11'd5, 16'd1, 250);
    run_phase(11'd2, 16'd16, 250);
    run_phase(11'd10, 16'd3, 150);

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
